>>> rtl/farc_pkg.sv
// farc_pkg: shared widths, codes and controller/datapath bundles for the
// fraction add/reduce/compare block. No dependencies.
`default_nettype none

package farc_pkg;

	localparam int FIELD_W   = 16;
	localparam int NUM_OUT_W = 33;
	localparam int DEN_OUT_W = 32;
	localparam int WIDTH_DEF = 16;

	// operand pair fed to the shared multiplier
	typedef enum logic [1:0] {
		MUL_LN_RD = 2'd0,
		MUL_RN_LD = 2'd1,
		MUL_LD_RD = 2'd2
	} farc_mul_sel_t;

	// what the shared divider is working on
	typedef enum logic [1:0] {
		DIV_EUC = 2'd0,
		DIV_NUM = 2'd1,
		DIV_DEN = 2'd2
	} farc_div_sel_t;

	typedef struct packed {
		logic          load;
		logic          mul_en;
		farc_mul_sel_t mul_sel;
		logic          euc_init;
		logic          div_start;
		farc_div_sel_t div_sel;
		logic          euc_step;
		logic          qn_store;
		logic          qd_store;
		logic          out_load;
	} farc_cmd_t;

	typedef struct packed {
		logic zero_den;
		logic op_cmp;
		logic b_zero;
		logic div_done;
	} farc_sts_t;

endpackage

`default_nettype wire

>>> rtl/farc_div.sv
// farc_div: unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by farc_dpath for Euclid remainders and final quotients.
`default_nettype none

module farc_div #(
	parameter int W = 33
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic      [W-1:0] quot,
	output logic      [W-1:0] rem,
	output logic              done
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quot_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         ge;
	logic [W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quot_q[W-1]};
		diff    = trial - {1'b0, dvsr_q};
		ge      = (trial >= {1'b0, dvsr_q});
		rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[W-2:0], ge};
			rem_q  <= rem_nxt;
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

>>> rtl/farc_dpath.sv
// farc_dpath: operand registers, shared multiplier, Euclid registers,
// divider instance and result register. Depends on farc_pkg, farc_div.
`default_nettype none

module farc_dpath #(
	parameter int WIDTH = farc_pkg::WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  op,
	input  wire logic signed [farc_pkg::FIELD_W-1:0]   left_num,
	input  wire logic signed [farc_pkg::FIELD_W-1:0]   left_den,
	input  wire logic signed [farc_pkg::FIELD_W-1:0]   right_num,
	input  wire logic signed [farc_pkg::FIELD_W-1:0]   right_den,
	input  wire farc_pkg::farc_cmd_t                   cmd,
	output farc_pkg::farc_sts_t                        sts,
	output logic signed [farc_pkg::NUM_OUT_W-1:0]      sum_num,
	output logic signed [farc_pkg::DEN_OUT_W-1:0]      sum_den,
	output logic                                       is_less,
	output logic                                       status
);

	import farc_pkg::*;

	// up to 16 bits: low WIDTH bits, signed; wider: the field zero-extended
	localparam int OPW = (WIDTH <= FIELD_W) ? WIDTH : FIELD_W + 1;
	localparam int PW  = 2 * OPW;
	localparam int NW  = PW + 1;

	function automatic logic signed [OPW-1:0] operand(input logic [FIELD_W-1:0] f);
		logic [FIELD_W:0] fx;
		fx = {1'b0, f};
		return fx[OPW-1:0];
	endfunction

	logic                  op_q;
	logic signed [OPW-1:0] ln_q, ld_q, rn_q, rd_q;
	logic signed [PW-1:0]  pa_q, pb_q, pd_q;
	logic signed [NW-1:0]  n_q;
	logic        [NW-1:0]  a_q, b_q;
	logic                  par_q;
	logic        [NW-1:0]  qn_q, qd_q;

	logic signed [NUM_OUT_W-1:0] sum_num_q;
	logic signed [DEN_OUT_W-1:0] sum_den_q;
	logic                        is_less_q;
	logic                        status_q;

	logic signed [OPW-1:0] ma, mb;
	logic signed [PW-1:0]  prod;
	logic signed [NW-1:0]  n_sum;
	logic        [NW-1:0]  n_sum_mag;
	logic signed [NW-1:0]  d_ext;
	logic        [NW-1:0]  n_mag, d_mag;
	logic                  n_neg, d_neg, g_neg;
	logic        [NW-1:0]  dv_dividend, dv_divisor, dv_quot, dv_rem;
	logic                  dv_done;
	logic signed [NW-1:0]  sn_w, sd_w;
	logic                  zero_den, lt;

	// shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MUL_LN_RD: begin ma = ln_q; mb = rd_q; end
			MUL_RN_LD: begin ma = rn_q; mb = ld_q; end
			MUL_LD_RD: begin ma = ld_q; mb = rd_q; end
			default:   begin ma = ln_q; mb = rd_q; end
		endcase
		prod = PW'(ma) * PW'(mb);
	end

	always_comb begin
		n_sum     = NW'(pa_q) + NW'(pb_q);
		n_sum_mag = n_sum[NW-1] ? unsigned'(-n_sum) : unsigned'(n_sum);
		d_ext     = NW'(pd_q);
		n_neg     = n_q[NW-1];
		d_neg     = pd_q[PW-1];
		n_mag     = n_neg ? unsigned'(-n_q) : unsigned'(n_q);
		d_mag     = d_neg ? unsigned'(-d_ext) : unsigned'(d_ext);
		zero_den  = (ld_q == '0) || (rd_q == '0);
		// remainders take the dividend's sign: even step count -> sign of n
		g_neg     = par_q ? d_neg : n_neg;
		sn_w      = (n_neg ^ g_neg) ? -signed'(qn_q) : signed'(qn_q);
		sd_w      = (d_neg ^ g_neg) ? -signed'(qd_q) : signed'(qd_q);
		// both dens nonzero here; product positive when signs agree
		lt        = (ld_q[OPW-1] == rd_q[OPW-1]) ? (pa_q < pb_q) : (pa_q > pb_q);
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_EUC: begin dv_dividend = a_q;   dv_divisor = b_q; end
			DIV_NUM: begin dv_dividend = n_mag; dv_divisor = a_q; end
			DIV_DEN: begin dv_dividend = d_mag; dv_divisor = a_q; end
			default: begin dv_dividend = a_q;   dv_divisor = b_q; end
		endcase
	end

	farc_div #(.W(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dv_dividend),
		.divisor  (dv_divisor),
		.quot     (dv_quot),
		.rem      (dv_rem),
		.done     (dv_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			ln_q <= operand(left_num);
			ld_q <= operand(left_den);
			rn_q <= operand(right_num);
			rd_q <= operand(right_den);
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MUL_LN_RD: pa_q <= prod;
				MUL_RN_LD: pb_q <= prod;
				MUL_LD_RD: pd_q <= prod;
				default:   pa_q <= pa_q;
			endcase
		end
		if (cmd.euc_init) begin
			n_q   <= n_sum;
			a_q   <= n_sum_mag;
			b_q   <= d_mag;
			par_q <= 1'b0;
		end else if (cmd.euc_step) begin
			a_q   <= b_q;
			b_q   <= dv_rem;
			par_q <= ~par_q;
		end
		if (cmd.qn_store) qn_q <= dv_quot;
		if (cmd.qd_store) qd_q <= dv_quot;
		if (cmd.out_load) begin
			if (zero_den) begin
				sum_num_q <= '0;
				sum_den_q <= '0;
				is_less_q <= 1'b0;
				status_q  <= 1'b1;
			end else if (op_q) begin
				sum_num_q <= '0;
				sum_den_q <= '0;
				is_less_q <= lt;
				status_q  <= 1'b0;
			end else begin
				sum_num_q <= NUM_OUT_W'(sn_w);
				sum_den_q <= DEN_OUT_W'(sd_w);
				is_less_q <= 1'b0;
				status_q  <= 1'b0;
			end
		end
	end

	assign sts.zero_den = zero_den;
	assign sts.op_cmp   = op_q;
	assign sts.b_zero   = (b_q == '0);
	assign sts.div_done = dv_done;

	assign sum_num = sum_num_q;
	assign sum_den = sum_den_q;
	assign is_less = is_less_q;
	assign status  = status_q;

endmodule

`default_nettype wire

>>> rtl/farc_ctrl.sv
// farc_ctrl: sequencing state machine and output word valid.
// Depends on farc_pkg.
`default_nettype none

module farc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire farc_pkg::farc_sts_t sts,
	output farc_pkg::farc_cmd_t      cmd
);

	import farc_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_MUL0  = 10'b00_0000_0010,
		S_MUL1  = 10'b00_0000_0100,
		S_MUL2  = 10'b00_0000_1000,
		S_EINIT = 10'b00_0001_0000,
		S_ETEST = 10'b00_0010_0000,
		S_EWAIT = 10'b00_0100_0000,
		S_QNW   = 10'b00_1000_0000,
		S_QDW   = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} farc_state_t;

	farc_state_t state_q, state_d;
	logic        out_valid_q;
	logic        accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.mul_sel   = MUL_LN_RD;
		cmd.div_sel   = DIV_EUC;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = S_MUL0;
				end
			end
			S_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LN_RD;
				state_d     = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RN_LD;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LD_RD;
				state_d     = (sts.zero_den || sts.op_cmp) ? S_DONE : S_EINIT;
			end
			S_EINIT: begin
				cmd.euc_init = 1'b1;
				state_d      = S_ETEST;
			end
			S_ETEST: begin
				cmd.div_start = 1'b1;
				if (sts.b_zero) begin
					cmd.div_sel = DIV_NUM;
					state_d     = S_QNW;
				end else begin
					cmd.div_sel = DIV_EUC;
					state_d     = S_EWAIT;
				end
			end
			S_EWAIT: begin
				cmd.div_sel = DIV_EUC;
				if (sts.div_done) begin
					cmd.euc_step = 1'b1;
					state_d      = S_ETEST;
				end
			end
			S_QNW: begin
				cmd.div_sel = DIV_NUM;
				if (sts.div_done) begin
					cmd.qn_store  = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_DEN;
					state_d       = S_QDW;
				end
			end
			S_QDW: begin
				cmd.div_sel = DIV_DEN;
				if (sts.div_done) begin
					cmd.qd_store = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result word overwritten while pending");

	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_EWAIT || state_q == S_QNW || state_q == S_QDW))
		else $error("divider finished outside a wait state");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MUL0))
		else $error("accepted word did not start the multiply sequence");

	a_short_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL2 && (sts.zero_den || sts.op_cmp)) |=> (state_q == S_DONE))
		else $error("compare or zero denominator entered the Euclid loop");

endmodule

`default_nettype wire

>>> rtl/fraction_add_reduce_compare_core.sv
// fraction_add_reduce_compare_core: top level, joins controller and datapath.
// Depends on farc_pkg, farc_ctrl, farc_dpath (and farc_div below it).
// Sequence: compare or zero denominator runs S_MUL0, S_MUL1, S_MUL2, S_DONE after accept.
// Add: adds S_EINIT, then S_ETEST/S_EWAIT per Euclid step and S_QNW, S_QDW on the
//   bit-serial divider, NW = 2 * OPW + 1 wide (33 at WIDTH 16); S_DONE waits on out_stall.
// Throughput: one word in flight; the next is taken once the result is queued.
// Reset: arst_n async active low clears the sequencer and output valid.
`default_nettype none

module fraction_add_reduce_compare_core #(
	parameter int WIDTH = farc_pkg::WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input word channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                op,
	input  wire logic signed [farc_pkg::FIELD_W-1:0] left_num,
	input  wire logic signed [farc_pkg::FIELD_W-1:0] left_den,
	input  wire logic signed [farc_pkg::FIELD_W-1:0] right_num,
	input  wire logic signed [farc_pkg::FIELD_W-1:0] right_den,
	// result word channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [farc_pkg::NUM_OUT_W-1:0]    sum_num,
	output logic signed [farc_pkg::DEN_OUT_W-1:0]    sum_den,
	output logic                                     is_less,
	output logic                                     status
);

	import farc_pkg::*;

	// Controller steps: three multiplies on one shared multiplier, then for add the
	// Euclid loop (one divider pass per remainder), then |n|/|g| and |d|/|g|.
	// The sign of g follows the parity of the Euclid steps, since truncating
	// remainders keep the dividend's sign.
	farc_cmd_t cmd;
	farc_sts_t sts;

	farc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath holds operands, products, Euclid pair and the result register;
	// the result register parts the output channel from the next word's work.
	farc_dpath #(.WIDTH(WIDTH)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.left_num  (left_num),
		.left_den  (left_den),
		.right_num (right_num),
		.right_den (right_den),
		.cmd       (cmd),
		.sts       (sts),
		.sum_num   (sum_num),
		.sum_den   (sum_den),
		.is_less   (is_less),
		.status    (status)
	);

endmodule

`default_nettype wire

>>> sim/tb_fraction_add_reduce_compare_core.sv
// tb_fraction_add_reduce_compare_core: self-checking bench for the fraction add/reduce/compare
// core. Directed then random words go through a queue-fed driver and a scoreboarded monitor.
// Depends on farc_pkg and fraction_add_reduce_compare_core.
module tb_fraction_add_reduce_compare_core;
	timeunit 1ns;
	timeprecision 1ps;

	import farc_pkg::*;

	localparam int OPW = WIDTH_DEF;

	// op codes and status codes of the word channels
	localparam logic OP_ADD      = 1'b0;
	localparam logic OP_LESS     = 1'b1;
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_ZERO_DEN = 1'b1;

	localparam int RANDOM_WORDS = 1130;
	// once this few words are left to send, both sides stop idling
	localparam int CALM_TAIL    = 60;
	// add words are the slowest; the limit allows several times the slowest run
	localparam int RUN_LIMIT_NS = 100_000_000;

	typedef struct {
		logic                      op;
		logic signed [FIELD_W-1:0] left_num;
		logic signed [FIELD_W-1:0] left_den;
		logic signed [FIELD_W-1:0] right_num;
		logic signed [FIELD_W-1:0] right_den;
		bit                        drain_first;	// hold back until nothing is outstanding
	} fraction_word_t;

	typedef struct {
		logic signed [NUM_OUT_W-1:0] sum_num;
		logic signed [DEN_OUT_W-1:0] sum_den;
		logic                        is_less;
		logic                        status;
	} fraction_answer_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic                        op        = OP_ADD;
	logic signed [FIELD_W-1:0]   left_num  = '0;
	logic signed [FIELD_W-1:0]   left_den  = '0;
	logic signed [FIELD_W-1:0]   right_num = '0;
	logic signed [FIELD_W-1:0]   right_den = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [NUM_OUT_W-1:0] sum_num;
	logic signed [DEN_OUT_W-1:0] sum_den;
	logic                        is_less;
	logic                        status;

	fraction_word_t   words_to_send[$];
	fraction_answer_t awaited_answers[$];
	fraction_word_t   word_on_bus;
	fraction_answer_t answer_due;
	int unsigned      send_idle = 0;
	int unsigned      recv_idle = 0;
	logic             calm      = 1'b0;
	int               mismatches = 0;

	fraction_add_reduce_compare_core #(
		.WIDTH(OPW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.left_num (left_num),
		.left_den (left_den),
		.right_num(right_num),
		.right_den(right_den),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_num  (sum_num),
		.sum_den  (sum_den),
		.is_less  (is_less),
		.status   (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Operand as the core sees it: low OPW bits, two's complement, when OPW fits the
	// field; the whole field read unsigned when it is wider.
	function automatic longint operand_of(logic [FIELD_W-1:0] raw);
		longint v;
		v = longint'(raw);
		if (OPW <= FIELD_W) begin
			v = v & ((64'sd1 <<< OPW) - 1);
			if (v[OPW-1])
				v = v - (64'sd1 <<< OPW);
		end
		return v;
	endfunction

	// Expected result word for one input word.
	function automatic fraction_answer_t fraction_outcome(fraction_word_t w);
		longint           ln, ld, rn, rd, n, d, g, r, t;
		fraction_answer_t res;
		ln = operand_of(w.left_num);
		ld = operand_of(w.left_den);
		rn = operand_of(w.right_num);
		rd = operand_of(w.right_den);
		res.sum_num = '0;
		res.sum_den = '0;
		res.is_less = 1'b0;
		res.status  = ST_OK;
		if (ld == 0 || rd == 0) begin
			res.status = ST_ZERO_DEN;
		end else if (w.op == OP_ADD) begin
			n = ln * rd + rn * ld;
			d = ld * rd;
			// Euclid on truncating remainder: g can come out negative and flip both signs;
			// a zero numerator leaves g = d, i.e. 0 over 1
			g = n;
			r = d;
			while (r != 0) begin
				t = r;
				r = g % r;
				g = t;
			end
			n = n / g;
			d = d / g;
			res.sum_num = n[NUM_OUT_W-1:0];
			res.sum_den = d[DEN_OUT_W-1:0];
		end else begin
			// cross-multiplied; sense flips when the denominator product is negative
			if (ld * rd > 0)
				res.is_less = (ln * rd < rn * ld);
			else
				res.is_less = (ln * rd > rn * ld);
		end
		return res;
	endfunction

	task automatic queue_word(logic o, int ln, int ld, int rn, int rd, bit drain = 1'b0);
		fraction_word_t w;
		w.op          = o;
		w.left_num    = ln[FIELD_W-1:0];
		w.left_den    = ld[FIELD_W-1:0];
		w.right_num   = rn[FIELD_W-1:0];
		w.right_den   = rd[FIELD_W-1:0];
		w.drain_first = drain;
		words_to_send.push_back(w);
	endtask

	// Mostly full-range values, with small values and the extremes mixed in so that
	// zero denominators, equal fractions and short Euclid runs turn up often.
	function automatic int random_field();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 12)
			return int'($urandom);
		if (pick < 17)
			return int'($urandom_range(0, 40)) - 20;
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 32767;
		endcase
	endfunction

	// Driver: presents the next queued word whenever the channel is free, with random
	// idle bursts until the tail of the run. A word marked drain_first
	// waits until every earlier result word has been taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			send_idle <= 0;
			calm      <= 1'b0;
		end else begin
			calm <= (words_to_send.size() < CALM_TAIL);
			if (in_valid && !in_stall)
				awaited_answers.push_back(fraction_outcome(word_on_bus));
			if (!in_valid || !in_stall) begin
				if (send_idle != 0) begin
					in_valid  <= 1'b0;
					send_idle <= send_idle - 1;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					in_valid  <= 1'b0;
					send_idle <= $urandom_range(0, 14);
				end else if (words_to_send.size() != 0 &&
				             !(words_to_send[0].drain_first && awaited_answers.size() != 0)) begin
					word_on_bus = words_to_send.pop_front();
					in_valid  <= 1'b1;
					op        <= word_on_bus.op;
					left_num  <= word_on_bus.left_num;
					left_den  <= word_on_bus.left_den;
					right_num <= word_on_bus.right_num;
					right_den <= word_on_bus.right_den;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each taken result word against the oldest expectation, field by
	// field, and stalls the result channel in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_idle <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_answers.size() == 0) begin
					$display("%0t ns: unexpected result word: expected none, got %0d/%0d less %0b status %0b",
					         $time, sum_num, sum_den, is_less, status);
					mismatches++;
				end else begin
					answer_due = awaited_answers.pop_front();
					if (sum_num !== answer_due.sum_num) begin
						$display("%0t ns: sum_num expected %0d, got %0d",
						         $time, answer_due.sum_num, sum_num);
						mismatches++;
					end
					if (sum_den !== answer_due.sum_den) begin
						$display("%0t ns: sum_den expected %0d, got %0d",
						         $time, answer_due.sum_den, sum_den);
						mismatches++;
					end
					if (is_less !== answer_due.is_less) begin
						$display("%0t ns: is_less expected %0b, got %0b",
						         $time, answer_due.is_less, is_less);
						mismatches++;
					end
					if (status !== answer_due.status) begin
						$display("%0t ns: status expected %0b, got %0b",
						         $time, answer_due.status, status);
						mismatches++;
					end
				end
			end
			if (recv_idle != 0) begin
				out_stall <= 1'b1;
				recv_idle <= recv_idle - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				recv_idle <= $urandom_range(0, 14);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		// directed words
		queue_word(OP_ADD, 1, 2, 1, 3);                  // plain 5/6
		queue_word(OP_ADD, 1, 2, -1, 2);                 // zero sum numerator
		queue_word(OP_ADD, 0, 5, 0, -7);                 // zero numerator, negative den product
		queue_word(OP_ADD, -32768, -32768, -32768, -32768); // largest positive sum
		queue_word(OP_ADD, 32767, 1, 32767, 1);
		queue_word(OP_ADD, -32768, 1, -32768, 1);
		queue_word(OP_ADD, 1, 32767, 1, -32768);
		queue_word(OP_ADD, 3, -4, 5, 6);                 // negative gcd path
		queue_word(OP_ADD, 32767, -32768, -32768, 32767);
		queue_word(OP_ADD, -1, -1, 0, -1);
		queue_word(OP_ADD, 7, 0, 3, 4);                  // zero denominators, add
		queue_word(OP_ADD, 7, 4, 3, 0);
		queue_word(OP_LESS, 7, 0, 3, 4);                 // zero denominators, compare
		queue_word(OP_LESS, 7, 4, 3, 0);
		queue_word(OP_LESS, 1, 0, 1, 0);
		queue_word(OP_LESS, 1, 2, 2, 3);
		queue_word(OP_LESS, 2, 3, 1, 2);
		queue_word(OP_LESS, 1, 2, 2, 4);                 // equal fractions
		queue_word(OP_LESS, 1, -2, 1, 3);                // one negative denominator
		queue_word(OP_LESS, 1, -2, 1, -3);               // both negative
		queue_word(OP_LESS, -32768, 1, 32767, 1);
		queue_word(OP_LESS, 32767, -32768, -32768, 32767);
		queue_word(OP_LESS, -32768, -32768, 32767, 32767);
		queue_word(OP_LESS, 0, -1, 0, 1);
		// random words; one halfway through waits for the core to drain
		for (int i = 0; i < RANDOM_WORDS; i++)
			queue_word(($urandom_range(0, 1) == 1) ? OP_LESS : OP_ADD,
			           random_field(), random_field(), random_field(), random_field(),
			           i == RANDOM_WORDS / 2);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || in_valid || awaited_answers.size() != 0)
			@(posedge clk);
		// watch a little longer for stray result words
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t ns: run limit reached", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> fraction_add_reduce_compare_core.f
rtl/farc_pkg.sv
rtl/farc_div.sv
rtl/farc_dpath.sv
rtl/farc_ctrl.sv
rtl/fraction_add_reduce_compare_core.sv
sim/tb_fraction_add_reduce_compare_core.sv
